FILE: hdl/tbpr_pkg.sv
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types, constants and helpers of the tile blitter with palette remap.
// ----------------------------------------------------------------------------
package tbpr_pkg;

  localparam int unsigned ROM_BYTES   = 2097152;
  localparam int unsigned TABLE_COUNT = 128;
  localparam int unsigned TAB_AW      = $clog2(TABLE_COUNT * 16);
  localparam int unsigned ROM_AW      = $clog2(ROM_BYTES);
  localparam int unsigned BANK_MASK   = ROM_BYTES / 32'h20000 - 1;

  // request codes
  localparam logic [1:0] REQ_TAB_WR = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PIX  = 2'd0;
  localparam logic [1:0] KIND_ADDR = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_SRC    = 3'd1;
  localparam logic [2:0] CFG_POS    = 3'd2;
  localparam logic [2:0] CFG_SIZEX  = 3'd3;
  localparam logic [2:0] CFG_PALNUM = 3'd4;
  localparam logic [2:0] CFG_PLANE  = 3'd5;
  localparam logic [2:0] CFG_SCROLL = 3'd6;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
    logic [3:0] table_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        plane;
    logic [8:0]  pix_x;
    logic [7:0]  pix_y;
    logic [7:0]  color;
    logic [20:0] rom_address;
    logic        last;
  } out_item_t;

  // work handed from the front to the back part
  typedef struct packed {
    logic        is_addr;  // address report, else a data byte
    logic [20:0] addr;
    logic [8:0]  x1;
    logic [8:0]  x2;
    logic [7:0]  y1;
    logic [7:0]  y2;
    logic [3:0]  c1;
    logic [3:0]  c2;
    logic        dual;
    logic [3:0]  psel;
    logic        done;
  } job_t;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [6:0] num,
                                                 input logic [3:0] idx);
    logic [6:0] t;
    t = 7'(32'(num) % TABLE_COUNT);
    return TAB_AW'({t, idx});
  endfunction

endpackage

FILE: hdl/tbpr_ram.sv
// ----------------------------------------------------------------------------
// tbpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/tbpr_front.sv
// ----------------------------------------------------------------------------
// tbpr_front
// Accepts requests, walks the blit rectangle and builds jobs for the back part.
// ----------------------------------------------------------------------------
module tbpr_front import tbpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        tab_we,
  output logic [TAB_AW-1:0] tab_waddr,
  output logic [7:0]  tab_wdata,
  output logic [6:0]  pal_num,
  output logic        job_push,
  output job_t        job_data,
  input  logic        job_full,
  input  logic        job_valid
);

  logic [3:0]  mode_r, lmode_r;
  logic [19:0] src_r;
  logic [7:0]  sizex_r, scroll_r;
  logic [6:0]  palnum_r;
  logic [3:0]  psel_r;
  logic [9:0]  ox_r, oy_r;
  logic [8:0]  col_r, row_r, cl_r, rl_r, cstart_r, ccount_r;
  logic        act_r;

  // a table write waits until the job queue is empty
  logic acc;
  assign in_stall = job_full || (in_data.req_type == REQ_TAB_WR && job_valid);
  assign acc      = in_valid && !in_stall;
  assign pal_num  = palnum_r;

  // table writes go straight to the ram
  assign tab_we    = acc && in_data.req_type == REQ_TAB_WR;
  assign tab_waddr = tab_addr(palnum_r, in_data.table_index);
  assign tab_wdata = in_data.value;

  // start address
  logic [3:0]  bank;
  logic [21:0] addr_full;
  logic [20:0] addr;
  always_comb begin
    bank = src_r[19:16];
    if (32'(bank) * 32'h20000 > ROM_BYTES - 1) bank = bank & 4'(BANK_MASK);
    addr_full = (22'(bank) << 17) + (22'(src_r[15:8]) << 9) + (22'(src_r[7:0]) << 1);
    if (32'(addr_full) > ROM_BYTES - 1) addr_full = addr_full & 22'(ROM_BYTES - 1);
    addr = addr_full[20:0];
  end

  // pixel coordinates of the current byte
  logic [7:0] sx, sy, off;
  logic [8:0] x1, x2;
  logic [7:0] y1, y2;
  logic [3:0] c1, c2;
  always_comb begin
    sx = 8'(ox_r + 10'(col_r));
    sy = 8'(oy_r + 10'(row_r));
    if (lmode_r[2]) begin
      off = scroll_r ^ 8'hff;
      x1  = {sx, 1'b0} ^ 9'h1ff;
      x2  = {sx, 1'b1} ^ 9'h1ff;
      y1  = sy ^ 8'hff;
      y2  = (sy + off + 8'd2) ^ 8'hff;
    end else begin
      off = scroll_r - 8'd1;
      x1  = {sx, 1'b0};
      x2  = {sx, 1'b1};
      y1  = sy;
      y2  = sy - off;
    end
    if (lmode_r[0]) begin
      c1 = in_data.value[7:4];
      c2 = in_data.value[3:0];
    end else begin
      c1 = in_data.value[3:0];
      c2 = in_data.value[7:4];
    end
  end

  logic [8:0] cl_dec, rl_dec;
  assign cl_dec = cl_r - 9'd1;
  assign rl_dec = rl_r - 9'd1;

  // job build
  always_comb begin
    job_push = acc && (in_data.req_type == REQ_START ||
                       (in_data.req_type == REQ_DATA && act_r));
    job_data         = '0;
    job_data.is_addr = in_data.req_type == REQ_START;
    job_data.addr    = addr;
    job_data.x1      = x1;
    job_data.x2      = x2;
    job_data.y1      = y1;
    job_data.y2      = y2;
    job_data.c1      = c1;
    job_data.c2      = c2;
    job_data.dual    = lmode_r[3];
    job_data.psel    = psel_r;
    job_data.done    = cl_dec == '0 && rl_dec == '0;
  end

  // walk and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 4'd8; lmode_r <= '0; src_r <= '0; sizex_r <= '0;
      scroll_r <= '0; palnum_r <= '0; psel_r <= '0;
      ox_r <= '0; oy_r <= '0; col_r <= '0; row_r <= '0; cl_r <= '0; rl_r <= '0;
      cstart_r <= '0; ccount_r <= '0; act_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_r   <= cfg_wdata[3:0];
          CFG_SRC:    src_r    <= cfg_wdata;
          CFG_POS: begin
            ox_r <= {2'b0, cfg_wdata[7:0] ^ 8'hff};
            oy_r <= {2'b0, cfg_wdata[15:8] ^ 8'hff};
          end
          CFG_SIZEX:  sizex_r  <= cfg_wdata[7:0];
          CFG_PALNUM: palnum_r <= cfg_wdata[6:0];
          CFG_PLANE:  psel_r   <= cfg_wdata[3:0];
          CFG_SCROLL: scroll_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (acc && in_data.req_type == REQ_START) begin
        lmode_r <= mode_r;
        if (mode_r[0]) begin
          ox_r     <= ox_r - {1'b0, sizex_r, 1'b0};
          cstart_r <= {1'b0, sizex_r};
          ccount_r <= 9'd256 - {1'b0, sizex_r};
          col_r    <= {1'b0, sizex_r};
          cl_r     <= 9'd256 - {1'b0, sizex_r};
        end else begin
          ox_r     <= ox_r - {2'b0, sizex_r};
          cstart_r <= '0;
          ccount_r <= {1'b0, sizex_r} + 9'd1;
          col_r    <= '0;
          cl_r     <= {1'b0, sizex_r} + 9'd1;
        end
        if (mode_r[1]) begin
          oy_r  <= oy_r - ({1'b0, in_data.value, 1'b0} + 10'd1);
          row_r <= {1'b0, in_data.value};
          rl_r  <= 9'd256 - {1'b0, in_data.value};
        end else begin
          oy_r  <= oy_r - {2'b0, in_data.value} - 10'd1;
          row_r <= '0;
          rl_r  <= {1'b0, in_data.value} + 9'd1;
        end
        act_r <= 1'b1;
      end else if (acc && in_data.req_type == REQ_DATA && act_r) begin
        if (cl_dec == '0) begin
          col_r <= cstart_r;
          cl_r  <= ccount_r;
          row_r <= lmode_r[1] ? row_r - 9'd1 : row_r + 9'd1;
          rl_r  <= rl_dec;
          if (rl_dec == '0) act_r <= 1'b0;
        end else begin
          col_r <= lmode_r[0] ? col_r - 9'd1 : col_r + 9'd1;
          cl_r  <= cl_dec;
        end
      end
    end
  end

  // an idle walk never pushes a data job
  assert property (@(posedge clk) disable iff (!rst_n)
    job_push && !job_data.is_addr |-> act_r)
    else $error("data job without active blit");
  assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> cl_r != '0)
    else $error("active walk with empty column count");

endmodule

FILE: hdl/tbpr_back.sv
// ----------------------------------------------------------------------------
// tbpr_back
// Looks up pens, emits up to five result transactions per job, one per cycle while the output does not stall.
// ----------------------------------------------------------------------------
module tbpr_back import tbpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job_data,
  output logic        job_pop,
  input  logic [6:0]  pal_num,
  output logic        rd_en,
  output logic [TAB_AW-1:0] rd_addr,
  input  logic [7:0]  rd_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  // two reads per data job: phase 0 pen 1, phase 1 pen 2, then emission
  logic [1:0] ph_r;
  logic [7:0] d1_r;
  logic [2:0] slot_r;
  logic       busy_r;

  logic [7:0] d1, d2;
  logic [4:0] want;
  logic       emit;
  logic [2:0] slot_sel;
  logic       has;

  // results to emit: p0 pix1, p0 pix2, p1 pix1, p1 pix2, done
  always_comb begin
    logic t1, t2, dual;
    d1 = d1_r;
    d2 = rd_data;
    dual = job_data.dual;
    t1 = d1 != 8'hff;
    t2 = d2 != 8'hff;
    if (dual && !job_data.psel[0]) begin
      if (!job_data.psel[3]) begin
        t1 = 1'b1;
        t2 = 1'b1;
      end
      if (d1 == 8'h7f) d1 = 8'hff;
      if (d2 == 8'h7f) d2 = 8'hff;
    end
    if (dual) begin
      want = {job_data.done, job_data.psel[1] & t2, job_data.psel[1] & t1,
              job_data.psel[0] & t2, job_data.psel[0] & t1};
    end else begin
      want = {job_data.done, 2'b00, t2, t1};
    end
  end

  // next slot at or above current
  logic [4:0] rem;
  logic [4:0] rem_hi;
  always_comb begin
    rem = want & ~((5'd1 << slot_r) - 5'd1);
    slot_sel = 3'd0;
    has = 1'b0;
    for (int i = 4; i >= 0; i--) begin
      if (rem[i]) begin
        slot_sel = 3'(i);
        has = 1'b1;
      end
    end
    rem_hi = rem & ~(5'd1 << slot_sel);
  end

  logic ostall;
  assign ostall = out_valid && out_stall;

  // pen 1 read on job start, pen 2 read in phase 1
  assign rd_en   = (!busy_r && job_valid && !job_data.is_addr) ||
                   (busy_r && ph_r == 2'd1);
  assign rd_addr = tab_addr(pal_num, ph_r[0] ? job_data.c2 : job_data.c1);
  assign emit    = busy_r && ph_r == 2'd2 && !ostall;

  logic is_addr_go;
  assign is_addr_go = job_valid && job_data.is_addr && !busy_r && !ostall;

  always_comb begin
    job_pop = is_addr_go || (emit && (!has || rem_hi == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; ph_r <= '0; slot_r <= '0; out_valid <= 1'b0;
    end else begin
      if (!ostall) out_valid <= 1'b0;
      if (is_addr_go) begin
        out_valid <= 1'b1;
        out_data  <= '{kind: KIND_ADDR, plane: 1'b0, pix_x: '0, pix_y: '0,
                       color: '0, rom_address: job_data.addr, last: 1'b1};
      end else if (!busy_r && job_valid && !job_data.is_addr) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd1;
        slot_r <= '0;
      end else if (busy_r && ph_r == 2'd1) begin
        d1_r <= rd_data;
        ph_r <= 2'd2;
      end else if (emit) begin
        if (has) begin
          out_valid <= 1'b1;
          out_data.kind  <= slot_sel == 3'd4 ? KIND_DONE : KIND_PIX;
          out_data.plane <= slot_sel == 3'd2 || slot_sel == 3'd3;
          out_data.pix_x <= slot_sel == 3'd4 ? 9'd0 :
                            (slot_sel[0] ? job_data.x2 : job_data.x1);
          out_data.pix_y <= slot_sel == 3'd4 ? 8'd0 :
                            ((job_data.dual && slot_sel < 3'd2) ? job_data.y1
                                                                 : job_data.y2);
          out_data.color <= slot_sel == 3'd4 ? 8'd0 : (slot_sel[0] ? d2 : d1);
          out_data.rom_address <= '0;
          out_data.last  <= rem_hi == '0;
        end
        slot_r <= slot_sel + 3'd1;
        if (!has || rem_hi == '0) busy_r <= 1'b0;
      end
    end
  end

  // pen 2 read data is held during emission since no read is enabled then; the job stays at head
  assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> job_valid && !job_data.is_addr)
    else $error("busy without data job");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last)
    else $error("done item not last");

endmodule

FILE: hdl/tbpr_queue.sv
// ----------------------------------------------------------------------------
// tbpr_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tbpr_queue import tbpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t       ent_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0]   cnt_r;

  assign full  = cnt_r == ($clog2(QDEPTH)+1)'(QDEPTH);
  assign valid = cnt_r != '0;
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ($clog2(QDEPTH)+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

FILE: hdl/tile_blitter_palette_remap.sv
// An address report passes through the job queue and the output register; a
// ROM byte passes through the job queue, its two pen reads and the output register.
// A ROM byte gives up to five results (possibly none), one per cycle unless the
// output stalls; its two pen reads share the single palette ram read port.
// A table write waits while jobs are queued.
// Reset: synchronous active-low rst_n clears walk, queue and output state.
// ----------------------------------------------------------------------------
// tile_blitter_palette_remap
// Rectangle blitter with palette table remap; top level.
// ----------------------------------------------------------------------------
module tile_blitter_palette_remap import tbpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic tab_we, rd_en, job_push, job_full, job_pop, job_valid;
  logic [TAB_AW-1:0] tab_waddr, rd_addr;
  logic [7:0] tab_wdata, rd_data;
  logic [6:0] pal_num;
  job_t job_in, job_head;

  // front part
  tbpr_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_data,
    .tab_we, .tab_waddr, .tab_wdata, .pal_num,
    .job_push, .job_data(job_in), .job_full, .job_valid
  );

  // job queue
  tbpr_queue u_queue (
    .clk, .rst_n, .push(job_push), .push_data(job_in), .full(job_full),
    .pop(job_pop), .valid(job_valid), .head(job_head)
  );

  // palette table
  tbpr_ram #(.WIDTH(8), .DEPTH(TABLE_COUNT * 16)) u_ram (
    .clk, .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
    .rd_en, .rd_addr, .rd_data
  );

  // back part
  tbpr_back u_back (
    .clk, .rst_n, .job_valid, .job_data(job_head), .job_pop, .pal_num,
    .rd_en, .rd_addr, .rd_data, .out_valid, .out_stall, .out_data
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the palette-remap rectangle blitter: a built-in
// shadow of the blitter predicts every pixel write, address report and done
// transaction, and the results are checked in order under random idling.
// ----------------------------------------------------------------------------
module testbench;
  import tbpr_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  tile_blitter_palette_remap dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the blitter state
  logic [7:0] pal_shadow [TABLE_COUNT*16];
  bit table_filled [TABLE_COUNT];
  int unsigned sh_mode, sh_src, sh_sizex, sh_palnum, sh_plane, sh_scroll;
  int unsigned org_x, org_y, col_pos, row_pos, cols_left, rows_left;
  int unsigned col_start, col_count, run_mode;
  bit blit_on;

  out_item_t blit_results_q [$];
  int unsigned n_items, n_pix, n_addr, n_done, n_errors;
  bit no_idle;

  // write one configuration register and mirror it
  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[19:0];
    @(posedge clk);
    case (idx)
      CFG_MODE: sh_mode = val & 4'hf;
      CFG_SRC: sh_src = val & 20'hfffff;
      CFG_POS: begin
        org_x = (val & 8'hff) ^ 8'hff;
        org_y = ((val >> 8) & 8'hff) ^ 8'hff;
      end
      CFG_SIZEX: sh_sizex = val & 8'hff;
      CFG_PALNUM: sh_palnum = val & 7'h7f;
      CFG_PLANE: sh_plane = val & 4'hf;
      CFG_SCROLL: sh_scroll = val & 8'hff;
      default: ;
    endcase
  endtask

  task automatic cfg_end();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic out_item_t make_res(int unsigned kind, int unsigned plane,
                                         int unsigned x, int unsigned y,
                                         int unsigned color, int unsigned addr);
    out_item_t r;
    r.kind = kind[1:0];
    r.plane = plane[0];
    r.pix_x = x[8:0];
    r.pix_y = y[7:0];
    r.color = color[7:0];
    r.rom_address = addr[20:0];
    r.last = 1'b0;
    return r;
  endfunction

  // predicted results of one accepted transaction
  task automatic predict_blit(input in_item_t it);
    out_item_t res [$];
    int unsigned v, base, bank, addr, sx, sy, x1, x2, y1, y2, off;
    int unsigned c1, c2, d1, d2;
    bit t1, t2;
    v = it.value;
    base = (sh_palnum % TABLE_COUNT) * 16;
    if (it.req_type == REQ_TAB_WR) begin
      pal_shadow[base + it.table_index] = it.value;
    end else if (it.req_type == REQ_START) begin
      run_mode = sh_mode;
      if (sh_mode & 1) begin
        org_x = (org_x - 2 * sh_sizex) & 10'h3ff;
        col_start = sh_sizex;
        col_count = 256 - sh_sizex;
      end else begin
        org_x = (org_x - sh_sizex) & 10'h3ff;
        col_start = 0;
        col_count = sh_sizex + 1;
      end
      if (sh_mode & 2) begin
        org_y = (org_y - (2 * v + 1)) & 10'h3ff;
        row_pos = v;
        rows_left = 256 - v;
      end else begin
        org_y = (org_y - v - 1) & 10'h3ff;
        row_pos = 0;
        rows_left = v + 1;
      end
      col_pos = col_start;
      cols_left = col_count;
      blit_on = 1;
      bank = (sh_src >> 16) & 4'hf;
      if (bank * 32'h20000 > ROM_BYTES - 1) bank &= ROM_BYTES / 32'h20000 - 1;
      addr = (bank << 17) + (((sh_src >> 8) & 8'hff) << 9) + ((sh_src & 8'hff) << 1);
      if (addr > ROM_BYTES - 1) addr &= ROM_BYTES - 1;
      res.push_back(make_res(KIND_ADDR, 0, 0, 0, 0, addr));
    end else if (it.req_type == REQ_DATA && blit_on) begin
      sx = (org_x + col_pos) & 8'hff;
      sy = (org_y + row_pos) & 8'hff;
      if (run_mode & 4) begin
        off = sh_scroll ^ 8'hff;
        x1 = ((sx * 2) ^ 9'h1ff) & 9'h1ff;
        x2 = ((sx * 2 + 1) ^ 9'h1ff) & 9'h1ff;
        y1 = sy ^ 8'hff;
        y2 = ((sy + off + 2) ^ 8'hff) & 8'hff;
      end else begin
        off = (sh_scroll - 1) & 8'hff;
        x1 = (sx * 2) & 9'h1ff;
        x2 = (sx * 2 + 1) & 9'h1ff;
        y1 = sy;
        y2 = (sy + ((0 - off) & 8'hff)) & 8'hff;
      end
      if (run_mode & 1) begin
        c1 = v >> 4;
        c2 = v & 4'hf;
      end else begin
        c1 = v & 4'hf;
        c2 = v >> 4;
      end
      d1 = pal_shadow[base + c1];
      d2 = pal_shadow[base + c2];
      if (run_mode & 8) begin
        if (sh_plane & 1) begin
          t1 = d1 != 8'hff;
          t2 = d2 != 8'hff;
        end else begin
          t1 = (sh_plane & 8) ? d1 != 8'hff : 1'b1;
          t2 = (sh_plane & 8) ? d2 != 8'hff : 1'b1;
          if (d1 == 8'h7f) d1 = 8'hff;
          if (d2 == 8'h7f) d2 = 8'hff;
        end
        if (sh_plane & 1) begin
          if (t1) res.push_back(make_res(KIND_PIX, 0, x1, y1, d1, 0));
          if (t2) res.push_back(make_res(KIND_PIX, 0, x2, y1, d2, 0));
        end
        if (sh_plane & 2) begin
          if (t1) res.push_back(make_res(KIND_PIX, 1, x1, y2, d1, 0));
          if (t2) res.push_back(make_res(KIND_PIX, 1, x2, y2, d2, 0));
        end
      end else begin
        if (d1 != 8'hff) res.push_back(make_res(KIND_PIX, 0, x1, y2, d1, 0));
        if (d2 != 8'hff) res.push_back(make_res(KIND_PIX, 0, x2, y2, d2, 0));
      end
      col_pos = (run_mode & 1) ? ((col_pos - 1) & 9'h1ff) : ((col_pos + 1) & 9'h1ff);
      cols_left = (cols_left - 1) & 9'h1ff;
      if (cols_left == 0) begin
        col_pos = col_start;
        cols_left = col_count;
        row_pos = (run_mode & 2) ? ((row_pos - 1) & 9'h1ff) : ((row_pos + 1) & 9'h1ff);
        rows_left = (rows_left - 1) & 9'h1ff;
        if (rows_left == 0) begin
          blit_on = 0;
          res.push_back(make_res(KIND_DONE, 0, 0, 0, 0, 0));
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) blit_results_q.push_back(res[i]);
  endtask

  // send one transaction, with a random gap before it
  task automatic send_item(input logic [1:0] req, input int unsigned val,
                           input int unsigned idx);
    in_item_t it;
    int unsigned gap;
    it.req_type = req;
    it.value = val[7:0];
    it.table_index = idx[3:0];
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_blit(it);
    n_items++;
  endtask

  // wait until every expected result has arrived, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blit_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random palette byte, biased toward the transparent and remap codes
  function automatic int unsigned pal_byte();
    case ($urandom_range(0, 5))
      0: return 8'hff;
      1: return 8'h7f;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic fill_table();
    for (int i = 0; i < 16; i++) send_item(REQ_TAB_WR, pal_byte(), i);
    table_filled[sh_palnum % TABLE_COUNT] = 1;
  endtask

  // extremes, every request type and the special cases
  task automatic test_directed();
    wait_idle();
    cfg_write(CFG_PALNUM, 0);
    cfg_write(CFG_PLANE, 4'hb);
    cfg_write(CFG_SCROLL, 0);
    cfg_write(CFG_POS, 16'hffff);
    cfg_write(CFG_SRC, 20'hfffff);
    cfg_write(CFG_SIZEX, 1);
    cfg_end();
    fill_table();
    send_item(REQ_DATA, 8'h5a, 0);          // data byte with no blit running
    send_item(2'd3, 8'hff, 4'hf);           // unknown request
    send_item(REQ_START, 0, 0);             // dual mode from reset, 2x1 blit
    send_item(REQ_DATA, 8'h00, 0);
    send_item(REQ_START, 1, 0);             // restart while running
    send_item(REQ_DATA, 8'hff, 4'hf);
    send_item(REQ_DATA, 8'h0f, 0);
    send_item(REQ_DATA, 8'hf0, 0);
    send_item(REQ_DATA, 8'h81, 0);
    wait_idle();
    cfg_write(CFG_MODE, 4'hf);
    cfg_write(CFG_SIZEX, 8'hff);
    cfg_write(CFG_SCROLL, 8'hff);
    cfg_write(CFG_PLANE, 4'h2);
    cfg_write(CFG_SRC, 0);
    cfg_end();
    send_item(REQ_START, 8'hff, 0);         // all flips, single pixel blit
    send_item(REQ_DATA, 8'h7e, 0);
    wait_idle();
    cfg_write(CFG_MODE, 0);
    cfg_write(CFG_SIZEX, 0);
    cfg_end();
    send_item(REQ_START, 0, 0);             // single plane mode
    send_item(REQ_DATA, 8'hc3, 0);
  endtask

  // random settings and well-formed blits with noise mixed in
  task automatic test_random_blits();
    int unsigned mode, sizex, rows;
    while (n_items < 400) begin
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 15);
      if (mode & 1) sizex = $urandom_range(252, 255);
      else sizex = $urandom_range(0, 3);
      cfg_write(CFG_MODE, mode);
      cfg_write(CFG_SIZEX, sizex);
      cfg_write(CFG_PLANE, $urandom_range(0, 15));
      cfg_write(CFG_SCROLL, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
      if ($urandom_range(0, 1)) cfg_write(CFG_POS, $urandom_range(0, 65535));
      if ($urandom_range(0, 1)) cfg_write(CFG_SRC, $urandom_range(0, 20'hfffff));
      if ($urandom_range(0, 2) == 0) cfg_write(CFG_PALNUM, $urandom_range(0, 127));
      cfg_end();
      if (!table_filled[sh_palnum % TABLE_COUNT]) fill_table();
      for (int b = 0; b < 2; b++) begin
        rows = (mode & 2) ? $urandom_range(252, 255) : $urandom_range(0, 3);
        send_item(REQ_START, rows, $urandom_range(0, 15));
        while (blit_on) begin
          case ($urandom_range(0, 19))
            0: send_item(REQ_TAB_WR, pal_byte(), $urandom_range(0, 15));
            1: send_item(2'd3, $urandom_range(0, 255), $urandom_range(0, 15));
            2: send_item(REQ_START, rows, $urandom_range(0, 15));
            default: send_item(REQ_DATA, $urandom_range(0, 255), $urandom_range(0, 15));
          endcase
        end
        if ($urandom_range(0, 3) == 0) send_item(REQ_DATA, $urandom_range(0, 255), 0);
      end
    end
    no_idle = 0;
  endtask

  // result side: random stall and in-order check
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (blit_results_q.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, out_data);
        n_errors++;
      end else begin
        exp_r = blit_results_q.pop_front();
        if (exp_r !== out_data) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
          n_errors++;
        end
        case (exp_r.kind)
          KIND_PIX: n_pix++;
          KIND_ADDR: n_addr++;
          default: n_done++;
        endcase
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
      out_stall <= (stall_left > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on cycles with no transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || cfg_we || (out_valid && !out_stall))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, blit_results_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    sh_mode = 8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_blits();
    wait_idle();
    $display("covered %0d transactions: %0d pixel writes, %0d address reports, %0d done",
             n_items, n_pix, n_addr, n_done);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: tile_blitter_palette_remap.f
hdl/tbpr_pkg.sv
hdl/tbpr_ram.sv
hdl/tbpr_front.sv
hdl/tbpr_back.sv
hdl/tbpr_queue.sv
hdl/tile_blitter_palette_remap.sv
tb/testbench.sv
